// ----- hdl/histogram_entropy_accumulator_defines.svh -----
// Assertion macros used by the checker of the entropy accumulator.
`ifndef HISTOGRAM_ENTROPY_ACCUMULATOR_DEFINES_SVH
`define HISTOGRAM_ENTROPY_ACCUMULATOR_DEFINES_SVH

// Same-cycle implication, ignored during reset.
`define HEA_ASSERT_NOW(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error("assertion failed");

// Next-cycle implication, ignored during reset.
`define HEA_ASSERT_NEXT(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error("assertion failed");

// Next-cycle implication that also holds across reset.
`define HEA_ASSERT_ALWAYS(label, clk, ante, cons) \
   label: assert property (@(posedge clk) (ante) |=> (cons)) \
      else $error("assertion failed");

`endif

// ----- hdl/hea_pkg.sv -----
package hea_pkg;

   localparam int DATA_BITS     = 32;
   localparam int CSR_ADDR_BITS = 2;
   localparam int CSR_DATA_BITS = 32;

   localparam logic [CSR_ADDR_BITS-1:0] CSR_ADDR_TOTAL_COUNT = 2'd0;

   localparam logic [DATA_BITS-1:0] TOTAL_COUNT_RESET = 32'd1;

   typedef enum logic [2:0] {
      ST_IDLE,
      ST_CHECK,
      ST_LOG,
      ST_DIFF,
      ST_MUL,
      ST_SUM
   } state_type;

endpackage

// ----- hdl/histogram_entropy_accumulator.sv -----
// Histogram entropy accumulator. Each word on req carries the cumulative end count of one
// bucket (tdata) and an end-of-histogram mark (tlast). For every bucket of length l the block
// adds (l/N)*log2(N/l) to a running sum in unsigned fixed point with FRAC_BITS fraction bits,
// N being the total_count register at byte address 0, and returns the saturated running sum on
// rsp (tdata), a flag for a bucket longer than N or a boundary that went backwards (tuser), and
// the copied end mark (tlast). The word after tlast starts a new histogram. A non-empty valid
// bucket goes through the states CHECK, LOG, DIFF, MUL and SUM, an empty or flagged one from
// CHECK straight to SUM. The logarithms come from the shared squaring multiplier, which runs
// both logarithms one fraction bit per cycle in turn, followed by a bit-serial product of
// probability and log difference. The restoring divider for l/N runs alongside the logarithms.
// A result waiting on rsp does not block the next input word.
module histogram_entropy_accumulator
   import hea_pkg::*;
#(
   parameter int COUNT_BITS = 32,
   parameter int FRAC_BITS  = 26
) (
   input  logic                     clock,
   input  logic                     reset,
   input  logic                     req_tvalid,
   output logic                     req_tready,
   input  logic [DATA_BITS-1:0]     req_tdata,   // [31:0] cumulative_end
   input  logic                     req_tlast,
   output logic                     rsp_tvalid,
   input  logic                     rsp_tready,
   output logic [DATA_BITS-1:0]     rsp_tdata,   // [31:0] entropy_sum
   output logic                     rsp_tuser,   // [0] bucket_error
   output logic                     rsp_tlast,
   input  logic                     csr_psel,
   input  logic                     csr_penable,
   input  logic                     csr_pwrite,
   input  logic [CSR_ADDR_BITS-1:0] csr_paddr,
   input  logic [CSR_DATA_BITS-1:0] csr_pwdata,
   output logic [CSR_DATA_BITS-1:0] csr_prdata,
   output logic                     csr_pready
);

   localparam int KW  = $clog2(COUNT_BITS);
   localparam int MW  = FRAC_BITS + 1;
   localparam int LW  = KW + FRAC_BITS;
   localparam int TW  = LW + 1;
   localparam int SW  = (TW + 1 > DATA_BITS + 1) ? TW + 1 : DATA_BITS + 1;
   localparam int CW  = $clog2(FRAC_BITS + 1);
   localparam int XW  = COUNT_BITS + FRAC_BITS;
   localparam logic [CW-1:0] LAST_ITER = CW'(FRAC_BITS - 1);
   localparam logic [CW-1:0] LAST_MUL  = CW'(FRAC_BITS);

   state_type state_ff, state_in;

   logic [DATA_BITS-1:0]  total_count_ff, total_count_in;
   logic [COUNT_BITS-1:0] prev_ff, prev_in;
   logic [DATA_BITS-1:0]  running_ff, running_in;
   logic [COUNT_BITS-1:0] bound_ff, bound_in;
   logic                  last_ff, last_in;
   logic                  err_ff, err_in;

   logic [MW-1:0]        mn_ff, mn_in, ml_ff, ml_in;
   logic [KW-1:0]        kn_ff, kn_in, kl_ff, kl_in;
   logic [FRAC_BITS-1:0] fn_ff, fn_in, fl_ff, fl_in;
   logic                 sel_ff, sel_in;
   logic [CW-1:0]        cnt_ff, cnt_in;

   logic [COUNT_BITS:0]  rem_ff, rem_in;
   logic [MW-1:0]        quo_ff, quo_in;

   logic [LW-1:0]        d_ff, d_in;
   logic [LW-1:0]        hi_ff, hi_in;
   logic                 lsb_ff, lsb_in;

   logic                  rsp_valid_ff, rsp_valid_in;
   logic [DATA_BITS-1:0]  rsp_data_ff, rsp_data_in;
   logic                  rsp_err_ff, rsp_err_in;
   logic                  rsp_last_ff, rsp_last_in;

   logic [COUNT_BITS-1:0] n_val;
   logic [COUNT_BITS:0]   len_wide;
   logic [COUNT_BITS-1:0] len_val;
   logic                  len_back, len_long, len_zero;
   logic [KW-1:0]         kn_norm, kl_norm;
   logic [MW-1:0]         mn_norm, ml_norm;
   logic [MW-1:0]         sq_a;
   logic [2*MW-1:0]       sq;
   logic [MW-1:0]         sq_m;
   logic [COUNT_BITS+1:0] rem2;
   logic                  div_ge;
   logic [LW-1:0]         ln_val, ll_val;
   logic [LW:0]           mul_sum;
   logic [TW-1:0]         term;
   logic [SW-1:0]         total_sum;
   logic [DATA_BITS-1:0]  sat_sum;
   logic                  csr_write;

   function automatic logic [KW-1:0] msb_index(input logic [COUNT_BITS-1:0] x);
      logic [KW-1:0] k;
      k = '0;
      for (int i = 1; i < COUNT_BITS; i++) begin
         if (x[i]) begin
            k = KW'(i);
         end
      end
      return k;
   endfunction

   // Place the leading one at bit FRAC_BITS, truncating bits shifted out.
   function automatic logic [MW-1:0] mantissa(input logic [COUNT_BITS-1:0] x,
                                              input logic [KW-1:0] k);
      logic [XW-1:0] wide;
      wide = {x, {FRAC_BITS{1'b0}}} >> k;
      return wide[MW-1:0];
   endfunction

   assign n_val    = total_count_ff[COUNT_BITS-1:0];
   assign len_wide = {1'b0, bound_ff} - {1'b0, prev_ff};
   assign len_val  = len_wide[COUNT_BITS-1:0];
   assign len_back = len_wide[COUNT_BITS];
   assign len_long = len_val > n_val;
   assign len_zero = len_val == '0;

   assign kn_norm = msb_index(n_val);
   assign kl_norm = msb_index(len_val);
   assign mn_norm = mantissa(n_val, kn_norm);
   assign ml_norm = mantissa(len_val, kl_norm);

   assign sq_a = sel_ff ? ml_ff : mn_ff;
   assign sq   = sq_a * sq_a;
   assign sq_m = sq[2*MW-1] ? sq[2*MW-1:MW] : sq[2*MW-2:MW-1];

   assign rem2   = {rem_ff, 1'b0};
   assign div_ge = rem2 >= {2'b00, n_val};

   assign ln_val = {kn_ff, fn_ff};
   assign ll_val = {kl_ff, fl_ff};

   assign mul_sum   = {1'b0, hi_ff} + (quo_ff[0] ? {1'b0, d_ff} : '0);
   assign term      = {hi_ff, lsb_ff};
   assign total_sum = SW'(running_ff) + SW'(term);
   assign sat_sum   = (|total_sum[SW-1:DATA_BITS]) ? '1 : total_sum[DATA_BITS-1:0];

   assign csr_write = csr_psel && csr_penable && csr_pwrite && csr_pready;

   always_comb begin
      state_in       = state_ff;
      total_count_in = total_count_ff;
      prev_in        = prev_ff;
      running_in     = running_ff;
      bound_in       = bound_ff;
      last_in        = last_ff;
      err_in         = err_ff;
      mn_in          = mn_ff;
      ml_in          = ml_ff;
      kn_in          = kn_ff;
      kl_in          = kl_ff;
      fn_in          = fn_ff;
      fl_in          = fl_ff;
      sel_in         = sel_ff;
      cnt_in         = cnt_ff;
      rem_in         = rem_ff;
      quo_in         = quo_ff;
      d_in           = d_ff;
      hi_in          = hi_ff;
      lsb_in         = lsb_ff;
      rsp_valid_in   = rsp_valid_ff && !rsp_tready;
      rsp_data_in    = rsp_data_ff;
      rsp_err_in     = rsp_err_ff;
      rsp_last_in    = rsp_last_ff;

      if (csr_write && csr_paddr == CSR_ADDR_TOTAL_COUNT) begin
         total_count_in = csr_pwdata;
      end

      unique case (state_ff)
         ST_IDLE: begin
            if (req_tvalid) begin
               bound_in = req_tdata[COUNT_BITS-1:0];
               last_in  = req_tlast;
               state_in = ST_CHECK;
            end
         end
         ST_CHECK: begin
            err_in = len_back || len_long;
            mn_in  = mn_norm;
            ml_in  = ml_norm;
            kn_in  = kn_norm;
            kl_in  = kl_norm;
            fn_in  = '0;
            fl_in  = '0;
            sel_in = 1'b0;
            cnt_in = '0;
            hi_in  = '0;
            lsb_in = 1'b0;
            // The top quotient bit is 1 only when the bucket spans all of N.
            quo_in = {{FRAC_BITS{1'b0}}, !len_long && !len_back && len_val == n_val};
            rem_in = {1'b0, (len_val == n_val) ? '0 : len_val};
            state_in = (len_back || len_long || len_zero) ? ST_SUM : ST_LOG;
         end
         ST_LOG: begin
            sel_in = !sel_ff;
            if (!sel_ff) begin
               mn_in  = sq_m;
               fn_in  = {fn_ff[FRAC_BITS-2:0], sq[2*MW-1]};
               quo_in = {quo_ff[MW-2:0], div_ge};
               rem_in = div_ge ? (COUNT_BITS+1)'(rem2 - {2'b00, n_val})
                               : rem2[COUNT_BITS:0];
            end else begin
               ml_in  = sq_m;
               fl_in  = {fl_ff[FRAC_BITS-2:0], sq[2*MW-1]};
               cnt_in = cnt_ff + 1'b1;
               if (cnt_ff == LAST_ITER) begin
                  state_in = ST_DIFF;
               end
            end
         end
         ST_DIFF: begin
            d_in     = (ln_val > ll_val) ? ln_val - ll_val : '0;
            cnt_in   = '0;
            state_in = ST_MUL;
         end
         ST_MUL: begin
            // Shift-add, probability bits from the LSB; keep only bits FRAC_BITS and up.
            hi_in  = mul_sum[LW:1];
            lsb_in = mul_sum[0];
            quo_in = quo_ff >> 1;
            cnt_in = cnt_ff + 1'b1;
            if (cnt_ff == LAST_MUL) begin
               state_in = ST_SUM;
            end
         end
         ST_SUM: begin
            if (!rsp_valid_ff || rsp_tready) begin
               rsp_valid_in = 1'b1;
               rsp_data_in  = sat_sum;
               rsp_err_in   = err_ff;
               rsp_last_in  = last_ff;
               prev_in      = last_ff ? '0 : bound_ff;
               running_in   = last_ff ? '0 : sat_sum;
               state_in     = ST_IDLE;
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff       <= ST_IDLE;
         total_count_ff <= TOTAL_COUNT_RESET;
         prev_ff        <= '0;
         running_ff     <= '0;
         rsp_valid_ff   <= 1'b0;
      end else begin
         state_ff       <= state_in;
         total_count_ff <= total_count_in;
         prev_ff        <= prev_in;
         running_ff     <= running_in;
         rsp_valid_ff   <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      bound_ff    <= bound_in;
      last_ff     <= last_in;
      err_ff      <= err_in;
      mn_ff       <= mn_in;
      ml_ff       <= ml_in;
      kn_ff       <= kn_in;
      kl_ff       <= kl_in;
      fn_ff       <= fn_in;
      fl_ff       <= fl_in;
      sel_ff      <= sel_in;
      cnt_ff      <= cnt_in;
      rem_ff      <= rem_in;
      quo_ff      <= quo_in;
      d_ff        <= d_in;
      hi_ff       <= hi_in;
      lsb_ff      <= lsb_in;
      rsp_data_ff <= rsp_data_in;
      rsp_err_ff  <= rsp_err_in;
      rsp_last_ff <= rsp_last_in;
   end

   assign req_tready = state_ff == ST_IDLE;
   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tdata  = rsp_data_ff;
   assign rsp_tuser  = rsp_err_ff;
   assign rsp_tlast  = rsp_last_ff;
   assign csr_pready = 1'b1;
   assign csr_prdata = (csr_paddr == CSR_ADDR_TOTAL_COUNT) ? total_count_ff : '0;

endmodule

// ----- hdl/hea_checker.sv -----
`include "histogram_entropy_accumulator_defines.svh"

module hea_checker (
   input logic clock,
   input logic reset,
   input logic req_tvalid,
   input logic req_tready,
   input logic rsp_tvalid,
   input logic rsp_tready
);

   `HEA_ASSERT_NEXT(a_rsp_hold, clock, reset, rsp_tvalid && !rsp_tready, rsp_tvalid)
   `HEA_ASSERT_NEXT(a_busy_after_accept, clock, reset, req_tvalid && req_tready, !req_tready)
   `HEA_ASSERT_NEXT(a_no_early_result, clock, reset, req_tvalid && req_tready, !rsp_tvalid || $past(rsp_tvalid) || $stable(rsp_tvalid))
   `HEA_ASSERT_ALWAYS(a_reset_clears, clock, reset, !rsp_tvalid && req_tready)

endmodule

bind histogram_entropy_accumulator hea_checker u_hea_checker (.*);

// ----- sim/tb_histogram_entropy_accumulator.sv -----
`timescale 1ns / 1ps

module tb_histogram_entropy_accumulator;
   import hea_pkg::*;

   localparam int FRAC = 26;
   localparam int LIMIT_CYCLES = 2_000_000;

   typedef struct packed {
      logic [31:0] sum;
      logic        err;
      logic        last;
   } entropy_word_type;

   logic clock = 1'b0;
   logic reset = 1'b1;
   logic req_tvalid = 1'b0;
   logic req_tready;
   logic [DATA_BITS-1:0] req_tdata = '0;
   logic req_tlast = 1'b0;
   logic rsp_tvalid;
   logic rsp_tready = 1'b0;
   logic [DATA_BITS-1:0] rsp_tdata;
   logic rsp_tuser;
   logic rsp_tlast;
   logic csr_psel = 1'b0;
   logic csr_penable = 1'b0;
   logic csr_pwrite = 1'b0;
   logic [CSR_ADDR_BITS-1:0] csr_paddr = '0;
   logic [CSR_DATA_BITS-1:0] csr_pwdata = '0;
   logic [CSR_DATA_BITS-1:0] csr_prdata;
   logic csr_pready;

   histogram_entropy_accumulator dut (.*);

   always #5 clock = ~clock;

   // predictor state
   logic [31:0] total_n;
   logic [31:0] prev_bound;
   logic [31:0] running_sum;
   entropy_word_type pending_sums[$];
   int  failures = 0;
   int  send_idle_pct = 0;
   int  recv_stall_pct = 0;
   longint cycle_count = 0;

   function automatic logic [63:0] log2_fixed(input logic [31:0] x);
      int k;
      logic [63:0] m;
      logic [63:0] frac;
      k = 0;
      frac = '0;
      if (x == 0) return '0;
      while (k < 31 && (x >> (k + 1)) != 0) k++;
      if (k <= FRAC) m = 64'(x) << (FRAC - k);
      else m = 64'(x) >> (k - FRAC);
      for (int i = 0; i < FRAC; i++) begin
         m = (m * m) >> FRAC;
         frac = frac << 1;
         if (m >= (64'd2 << FRAC)) begin
            frac[0] = 1'b1;
            m = m >> 1;
         end
      end
      return (64'(k) << FRAC) | frac;
   endfunction

   function automatic entropy_word_type add_bucket(input logic [31:0] bound, input logic last);
      entropy_word_type r;
      logic [31:0] len;
      logic [63:0] term;
      logic [63:0] ln;
      logic [63:0] ll;
      logic [63:0] d;
      logic [63:0] p;
      logic [63:0] s;
      term = '0;
      r.err = 1'b0;
      if (bound < prev_bound) r.err = 1'b1;
      else begin
         len = bound - prev_bound;
         if (len > total_n) r.err = 1'b1;
         else if (len > 0) begin
            ln = log2_fixed(total_n);
            ll = log2_fixed(len);
            d = (ln > ll) ? ln - ll : 64'd0;
            p = (64'(len) << FRAC) / 64'(total_n);
            term = (p * d) >> FRAC;
         end
      end
      prev_bound = bound;
      s = 64'(running_sum) + term;
      if (s > 64'hFFFF_FFFF) s = 64'hFFFF_FFFF;
      running_sum = s[31:0];
      r.sum = s[31:0];
      r.last = last;
      if (last) begin
         prev_bound = '0;
         running_sum = '0;
      end
      return r;
   endfunction

   always @(posedge clock) begin
      cycle_count <= cycle_count + 1;
      if (cycle_count > LIMIT_CYCLES) begin
         $display("histogram_entropy_accumulator: mismatch");
         $finish;
      end
   end

   // check results
   always @(posedge clock) begin
      entropy_word_type want;
      if (!reset && rsp_tvalid && rsp_tready) begin
         if (pending_sums.size() == 0) begin
            $display("%0t unexpected word: sum %h err %b last %b", $time,
                     rsp_tdata, rsp_tuser, rsp_tlast);
            failures++;
         end else begin
            want = pending_sums.pop_front();
            if (want.sum !== rsp_tdata || want.err !== rsp_tuser
                || want.last !== rsp_tlast) begin
               $display("%0t expected sum %h err %b last %b, got sum %h err %b last %b",
                        $time, want.sum, want.err, want.last,
                        rsp_tdata, rsp_tuser, rsp_tlast);
               failures++;
            end
         end
      end
   end

   // receiver stalls
   always @(negedge clock)
      rsp_tready <= ($urandom_range(99) >= recv_stall_pct);

   // Leaves tvalid high at the closing negedge; the next send or a drain drives it.
   task automatic send_bucket(input logic [31:0] bound, input logic last);
      while ($urandom_range(99) < send_idle_pct) begin
         req_tvalid <= 1'b0;
         @(negedge clock);
      end
      req_tvalid <= 1'b1;
      req_tdata <= bound;
      req_tlast <= last;
      @(posedge clock);
      while (!req_tready) @(posedge clock);
      pending_sums.push_back(add_bucket(bound, last));
      @(negedge clock);
   endtask

   task automatic drain_results();
      req_tvalid <= 1'b0;
      while (pending_sums.size() != 0) @(posedge clock);
      repeat (100) @(posedge clock);
      @(negedge clock);
   endtask

   task automatic write_total(input logic [31:0] value);
      csr_psel <= 1'b1;
      csr_pwrite <= 1'b1;
      csr_paddr <= CSR_ADDR_TOTAL_COUNT;
      csr_pwdata <= value;
      @(negedge clock);
      csr_penable <= 1'b1;
      @(negedge clock);
      csr_psel <= 1'b0;
      csr_penable <= 1'b0;
      csr_pwrite <= 1'b0;
      total_n = value;
   endtask

   function automatic logic [31:0] rand_word();
      case ($urandom_range(3))
         0: return $urandom_range(255);
         1: return 32'hFFFF_FFFF - $urandom_range(255);
         default: return $urandom;
      endcase
   endfunction

   task automatic test_directed();
      send_bucket(32'd0, 1'b0);              // empty bucket
      send_bucket(32'd1, 1'b0);              // full length N=1
      send_bucket(32'd3, 1'b1);              // too long
      drain_results();
      write_total(32'd8);
      send_bucket(32'd2, 1'b0);
      send_bucket(32'd4, 1'b0);
      send_bucket(32'd1, 1'b0);              // boundary backwards
      send_bucket(32'd8, 1'b1);
      drain_results();
      write_total(32'd0);                    // zero total
      send_bucket(32'd0, 1'b0);
      send_bucket(32'd5, 1'b1);
      drain_results();
      write_total(32'hFFFF_FFFF);
      send_bucket(32'h0000_0001, 1'b0);
      send_bucket(32'h7FFF_FFFF, 1'b0);
      send_bucket(32'hFFFF_FFFF, 1'b1);
      send_bucket(32'hFFFF_FFFF, 1'b0);
      send_bucket(32'h0000_0000, 1'b1);
      drain_results();
      // many short buckets against a small total push the sum into saturation
      write_total(32'd3);
      for (int i = 1; i <= 200; i++) send_bucket(i, i == 200);
      drain_results();
   endtask

   task automatic test_random(input int n_items, input int idle, input int stall);
      logic [31:0] bound;
      send_idle_pct = idle;
      recv_stall_pct = stall;
      for (int i = 0; i < n_items; i++) begin
         if ($urandom_range(9) == 0) begin
            bound = rand_word();
         end else if (total_n != 0) begin
            // well-formed: advance by a length within N
            if ($urandom_range(3) == 0) bound = prev_bound + (total_n - prev_bound) / 2;
            else bound = prev_bound + $urandom_range(total_n < 64 ? total_n : 64);
            if (bound < prev_bound) bound = 32'hFFFF_FFFF;
         end else begin
            bound = prev_bound;
         end
         send_bucket(bound, $urandom_range(15) == 0);
         if (i == n_items / 2) drain_results();  // sender waits for all results
      end
      drain_results();
   endtask

   initial begin
      prev_bound = '0;
      running_sum = '0;
      total_n = TOTAL_COUNT_RESET;
      repeat (2) @(negedge clock);
      reset <= 1'b0;
      @(negedge clock);
      test_directed();
      write_total(32'd1000);
      test_random(310, 0, 0);
      write_total(32'hFFFF_FFFF);
      test_random(310, 74, 0);
      write_total(32'd1);
      test_random(310, 0, 74);
      write_total($urandom_range(2000, 2));
      test_random(310, 30, 30);
      if (failures == 0) $display("histogram_entropy_accumulator: match");
      else $display("histogram_entropy_accumulator: mismatch");
      $finish;
   end

endmodule

// ----- files.f -----
+incdir+hdl
hdl/hea_pkg.sv
hdl/histogram_entropy_accumulator.sv
hdl/hea_checker.sv
sim/tb_histogram_entropy_accumulator.sv
